[hw/rtl/sorted_list_engine_defines.svh]
// assertion macros for the sorted list engine
`ifndef SORTED_LIST_ENGINE_DEFINES_SVH
`define SORTED_LIST_ENGINE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// implication or plain property checked on every clock outside reset
`define SLE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// condition that must never be seen outside reset
`define SLE_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SLE_ASSERT(lbl, clk, rst, prop, msg)
`define SLE_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

[hw/rtl/sle_pkg.sv]
`default_nettype none

package sle_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 4;
  localparam int CMD_W        = 2;
  localparam int STATUS_W     = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_LISTED    = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    ELEM_VAL  = 2'd0,
    ELEM_RAM  = 2'd1,
    ELEM_ZERO = 2'd2
  } elem_sel_t;

  typedef enum logic {
    RD_IDX  = 1'b0,
    RD_MOVE = 1'b1
  } rd_sel_t;

  typedef enum logic {
    WR_VAL = 1'b0,
    WR_RAM = 1'b1
  } wr_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      load;
    logic      idx_inc;
    logic      ptr_load;
    logic      ptr_step;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_en;
    wr_sel_t   wr_sel;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      emit;
    status_t   res_status;
    elem_sel_t elem_sel;
    logic      pos_zero;
    logic      list_mode;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic full;
    logic empty;
    logic scan_end;
    logic hit;
    logic move_done;
    logic list_last;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/sle_ram.sv]
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sle_ctrl.sv]
`default_nettype none

module sle_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire sle_pkg::sts_t sts,
  output sle_pkg::ctl_t      ctl,
  output logic               busy
);

  import sle_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_SCAN_REQ = 9'b000000100,
    S_SCAN_CHK = 9'b000001000,
    S_MOVE_RD  = 9'b000010000,
    S_MOVE_WR  = 9'b000100000,
    S_LIST_RD  = 9'b001000000,
    S_LIST_OUT = 9'b010000000,
    S_SPARE    = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (sts.cmd == CMD_INSERT && sts.full) begin
          ctl.emit       = 1'b1;
          ctl.res_status = ST_FULL;
          ctl.elem_sel   = ELEM_VAL;
          ctl.pos_zero   = 1'b1;
          state_next     = S_IDLE;
        end else if (sts.cmd == CMD_LIST && sts.empty) begin
          ctl.emit       = 1'b1;
          ctl.res_status = ST_EMPTY;
          ctl.elem_sel   = ELEM_ZERO;
          ctl.pos_zero   = 1'b1;
          state_next     = S_IDLE;
        end else if (sts.cmd == CMD_LIST) begin
          state_next = S_LIST_RD;
        end else begin
          state_next = S_SCAN_REQ;
        end
      end
      S_SCAN_REQ: begin
        if (sts.scan_end) begin
          if (sts.cmd == CMD_INSERT) begin
            ctl.ptr_load = 1'b1;
            state_next   = S_MOVE_RD;
          end else begin
            ctl.emit       = 1'b1;
            ctl.res_status = ST_NOT_FOUND;
            ctl.elem_sel   = ELEM_VAL;
            ctl.pos_zero   = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_IDX;
          state_next = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (!sts.hit) begin
          ctl.idx_inc = 1'b1;
          state_next  = S_SCAN_REQ;
        end else if (sts.cmd == CMD_SEARCH) begin
          ctl.emit       = 1'b1;
          ctl.res_status = ST_FOUND;
          ctl.elem_sel   = ELEM_VAL;
          state_next     = S_IDLE;
        end else begin
          ctl.ptr_load = 1'b1;
          state_next   = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        if (sts.move_done) begin
          ctl.emit     = 1'b1;
          ctl.elem_sel = ELEM_VAL;
          state_next   = S_IDLE;
          if (sts.cmd == CMD_INSERT) begin
            ctl.wr_en      = 1'b1;
            ctl.wr_sel     = WR_VAL;
            ctl.cnt_inc    = 1'b1;
            ctl.res_status = ST_INSERTED;
          end else begin
            ctl.cnt_dec    = 1'b1;
            ctl.res_status = ST_DELETED;
          end
        end else begin
          ctl.rd_en  = 1'b1;
          ctl.rd_sel = RD_MOVE;
          state_next = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        ctl.wr_en    = 1'b1;
        ctl.wr_sel   = WR_RAM;
        ctl.ptr_step = 1'b1;
        state_next   = S_MOVE_RD;
      end
      S_LIST_RD: begin
        ctl.rd_en  = 1'b1;
        ctl.rd_sel = RD_IDX;
        state_next = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        ctl.emit       = 1'b1;
        ctl.res_status = ST_LISTED;
        ctl.elem_sel   = ELEM_RAM;
        ctl.list_mode  = 1'b1;
        ctl.idx_inc    = 1'b1;
        state_next     = sts.list_last ? S_IDLE : S_LIST_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/sle_datapath.sv]
`default_nettype none

module sle_datapath #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [sle_pkg::CMD_W-1:0]          command,
  input  wire logic signed [sle_pkg::DATA_W-1:0]  value,
  input  wire sle_pkg::ctl_t                      ctl,
  output sle_pkg::sts_t                           sts,
  output logic                                    strobe,
  output logic [sle_pkg::STATUS_W-1:0]            status,
  output logic signed [sle_pkg::DATA_W-1:0]       element,
  output logic [sle_pkg::POS_W-1:0]               position,
  output logic                                    last
);

  import sle_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int IW = $clog2(CAPACITY + 1);

  cmd_t                     cmd;
  logic signed [DATA_W-1:0] val;
  logic [IW-1:0]            idx;
  logic [IW-1:0]            ptr;
  logic [IW-1:0]            count;

  logic [AW-1:0]            raddr;
  logic [DATA_W-1:0]        wdata;
  logic [DATA_W-1:0]        rdata;
  logic signed [DATA_W-1:0] rdata_s;
  logic                     is_insert;

  assign is_insert = (cmd == CMD_INSERT);
  assign rdata_s   = $signed(rdata);

  // insert shifts toward the tail, delete toward the head
  always_comb begin
    unique case (ctl.rd_sel)
      RD_IDX:  raddr = AW'(idx);
      RD_MOVE: raddr = is_insert ? AW'(ptr - IW'(1)) : AW'(ptr + IW'(1));
      default: raddr = AW'(idx);
    endcase
  end

  assign wdata = (ctl.wr_sel == WR_RAM) ? rdata : val;

  sle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (AW'(ptr)),
    .wdata (wdata),
    .re    (ctl.rd_en),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= cmd_t'(command);
      val <= value;
    end
    if (ctl.load) begin
      idx <= '0;
    end else if (ctl.idx_inc) begin
      idx <= idx + IW'(1);
    end
    if (ctl.ptr_load) begin
      ptr <= is_insert ? count : idx;
    end else if (ctl.ptr_step) begin
      ptr <= is_insert ? (ptr - IW'(1)) : (ptr + IW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.cnt_inc) begin
      count <= count + IW'(1);
    end else if (ctl.cnt_dec) begin
      count <= count - IW'(1);
    end
  end

  // insert stops at the first entry not smaller, delete and search at the first equal one
  always_comb begin
    sts.cmd       = cmd;
    sts.full      = (count == IW'(CAPACITY));
    sts.empty     = (count == '0);
    sts.scan_end  = (idx == count);
    sts.hit       = is_insert ? !(rdata_s < val) : (rdata_s == val);
    sts.move_done = is_insert ? (ptr == idx) : ((ptr + IW'(1)) == count);
    sts.list_last = ((idx + IW'(1)) == count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      status   <= ctl.res_status;
      position <= ctl.pos_zero ? '0 : POS_W'(idx);
      last     <= ctl.list_mode ? sts.list_last : 1'b1;
      unique case (ctl.elem_sel)
        ELEM_VAL:  element <= val;
        ELEM_RAM:  element <= rdata_s;
        ELEM_ZERO: element <= '0;
        default:   element <= val;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/sorted_list_engine.sv]
// channel   direction  ports                                  transaction
// command   in         start, command, value                  start high while busy low
// result    out        strobe, status, element, position, last  strobe high for one cycle
//
// one command at a time; busy stays high from acceptance until its last result is issued
// insert, delete, search: a scan over the entries, then a shift for an insert or a found delete;
// the scan and the shift read each entry through the registered read of the entry ram
// list: one result per entry, read from the ram; empty list or full insert: one result from dispatch
// synchronous reset clears the fill count, the controller and the result strobe
// results cannot be stalled: each is shown for exactly one cycle
`default_nettype none

`include "sorted_list_engine_defines.svh"

module sorted_list_engine #(
  parameter int CAPACITY = sle_pkg::CAPACITY_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic [sle_pkg::CMD_W-1:0]          command,
  input  wire logic signed [sle_pkg::DATA_W-1:0]  value,
  output logic                                    busy,
  output logic                                    strobe,
  output logic [sle_pkg::STATUS_W-1:0]            status,
  output logic signed [sle_pkg::DATA_W-1:0]       element,
  output logic [sle_pkg::POS_W-1:0]               position,
  output logic                                    last
);

  import sle_pkg::*;

  ctl_t ctl;
  sts_t sts;

  sle_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .command  (command),
    .value    (value),
    .ctl      (ctl),
    .sts      (sts),
    .strobe   (strobe),
    .status   (status),
    .element  (element),
    .position (position),
    .last     (last)
  );

  `SLE_ASSERT(a_result_from_work, clk, rst, strobe |-> $past(busy), "result without a transaction")
  `SLE_ASSERT(a_accept_busy, clk, rst, (start && !busy) |=> busy, "accepted command left idle")
  `SLE_NEVER(a_insert_when_full, clk, rst, ctl.cnt_inc && sts.full, "insert into a full list")
  `SLE_NEVER(a_write_idle, clk, rst, ctl.wr_en && !busy, "ram written while idle")

endmodule

`default_nettype wire

[test/sorted_list_engine_test.sv]
`timescale 1ns / 100ps

module sorted_list_engine_test;
  import sle_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic signed [DATA_W-1:0] MIN_V = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] MAX_V = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 343;
  localparam int DRAIN_CYCLES = 2 * CAP + 16;

  typedef struct {
    status_t                   st;
    logic signed [DATA_W-1:0]  el;
    logic [POS_W-1:0]          pos;
    logic                      lst;
  } result_t;

  typedef struct {
    cmd_t                      cmd;
    logic signed [DATA_W-1:0]  val;
    bit                        typed;
    result_t                   res;
  } plan_row_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic [CMD_W-1:0]          command;
  logic signed [DATA_W-1:0]  value;
  logic                      busy;
  logic                      strobe;
  logic [STATUS_W-1:0]       status;
  logic signed [DATA_W-1:0]  element;
  logic [POS_W-1:0]          position;
  logic                      last;

  // shadow copy of the sorted list
  logic signed [DATA_W-1:0]  stored_vals [CAP];
  int                        stored_count;

  result_t                   cmd_results [$];
  result_t                   expected_results [$];
  plan_row_t                 plan [$];

  int n_commands;
  int n_checked;
  int n_errors;
  int n_full;
  int n_miss;
  int n_empty_list;
  int n_longest_list;

  sorted_list_engine #(
    .CAPACITY(CAP)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .command  (command),
    .value    (value),
    .busy     (busy),
    .strobe   (strobe),
    .status   (status),
    .element  (element),
    .position (position),
    .last     (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("FAILURE");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    n_errors++;
  endtask

  task automatic add_result(input status_t st, input logic signed [DATA_W-1:0] el,
                            input int pos, input logic lst);
    result_t r;
    r.st  = st;
    r.el  = el;
    r.pos = pos[POS_W-1:0];
    r.lst = lst;
    cmd_results.push_back(r);
  endtask

  // updates the shadow list and fills cmd_results with what the command yields
  task automatic apply_command(input cmd_t c, input logic signed [DATA_W-1:0] v);
    int i;
    int j;
    cmd_results.delete();
    case (c)
      CMD_INSERT: begin
        if (stored_count >= CAP) begin
          add_result(ST_FULL, v, 0, 1'b1);
          n_full++;
        end else begin
          i = 0;
          while (i < stored_count && stored_vals[i] < v) i++;
          for (j = stored_count; j > i; j--) stored_vals[j] = stored_vals[j-1];
          stored_vals[i] = v;
          stored_count++;
          add_result(ST_INSERTED, v, i, 1'b1);
        end
      end
      CMD_DELETE, CMD_SEARCH: begin
        i = 0;
        while (i < stored_count && stored_vals[i] !== v) i++;
        if (i >= stored_count) begin
          add_result(ST_NOT_FOUND, v, 0, 1'b1);
          n_miss++;
        end else if (c == CMD_DELETE) begin
          for (j = i; j + 1 < stored_count; j++) stored_vals[j] = stored_vals[j+1];
          stored_count--;
          add_result(ST_DELETED, v, i, 1'b1);
        end else begin
          add_result(ST_FOUND, v, i, 1'b1);
        end
      end
      default: begin
        if (stored_count == 0) begin
          add_result(ST_EMPTY, '0, 0, 1'b1);
          n_empty_list++;
        end else begin
          for (i = 0; i < stored_count; i++)
            add_result(ST_LISTED, stored_vals[i], i, (i + 1 == stored_count));
          if (stored_count > n_longest_list) n_longest_list = stored_count;
        end
      end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send(input cmd_t c, input logic signed [DATA_W-1:0] v, input int gap,
                      input bit typed, input result_t typed_res);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start   = 1'b1;
    command = c;
    value   = v;
    do @(posedge clk); while (busy);
    apply_command(c, v);
    if (typed) begin
      expected_results.push_back(typed_res);
    end else begin
      foreach (cmd_results[k]) expected_results.push_back(cmd_results[k]);
    end
    n_commands++;
    @(negedge clk);
  endtask

  task automatic plan_row(input cmd_t c, input logic signed [DATA_W-1:0] v, input bit typed,
                          input status_t st, input logic signed [DATA_W-1:0] el,
                          input int pos);
    plan_row_t p;
    p.cmd     = c;
    p.val     = v;
    p.typed   = typed;
    p.res.st  = st;
    p.res.el  = el;
    p.res.pos = pos[POS_W-1:0];
    p.res.lst = 1'b1;
    plan.push_back(p);
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status=%0d element=%0d position=%0d last=%0b",
                                status, element, position, last));
      end else begin
        want = expected_results.pop_front();
        n_checked++;
        if (status !== want.st || element !== want.el || position !== want.pos ||
            last !== want.lst)
          flag_mismatch($sformatf({"got st=%0d el=%0d pos=%0d last=%0b, ",
                                   "exp st=%0d el=%0d pos=%0d last=%0b"},
                                  status, element, position, last,
                                  want.st, want.el, want.pos, want.lst));
      end
    end
  end

  initial begin : stimulus
    result_t                   none;
    logic signed [DATA_W-1:0]  pool [8];
    logic signed [DATA_W-1:0]  v;
    cmd_t                      c;
    bit                        filling;
    bit                        no_idle;
    int                        r;
    int                        ins_pct;
    int                        gap;

    rst     = 1'b1;
    start   = 1'b0;
    command = CMD_INSERT;
    value   = '0;
    none    = '{ST_INSERTED, '0, '0, 1'b0};
    stored_count = 0;
    n_commands = 0;
    n_checked = 0;
    n_errors = 0;
    n_full = 0;
    n_miss = 0;
    n_empty_list = 0;
    n_longest_list = 0;
    foreach (stored_vals[k]) stored_vals[k] = '0;

    // empty list, extremes, duplicates, then fill to capacity
    plan_row(CMD_LIST,   32'sh1234_5678, 1, ST_EMPTY,     '0,    0);
    plan_row(CMD_DELETE, 32'sd5,         1, ST_NOT_FOUND, 32'sd5, 0);
    plan_row(CMD_SEARCH, MIN_V,          1, ST_NOT_FOUND, MIN_V, 0);
    plan_row(CMD_INSERT, MAX_V,          1, ST_INSERTED,  MAX_V, 0);
    plan_row(CMD_INSERT, MIN_V,          1, ST_INSERTED,  MIN_V, 0);
    plan_row(CMD_INSERT, 32'sd0,         0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, 32'sd0,         0, ST_INSERTED,  '0,    0);
    plan_row(CMD_SEARCH, 32'sd0,         0, ST_INSERTED,  '0,    0);
    plan_row(CMD_DELETE, 32'sd0,         0, ST_INSERTED,  '0,    0);
    plan_row(CMD_SEARCH, 32'sd7,         1, ST_NOT_FOUND, 32'sd7, 0);
    plan_row(CMD_LIST,   32'sd0,         0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, -32'sd1,        0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, 32'sd1,         0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, 32'sh5555_5555, 0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, 32'shAAAA_AAAA, 0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, MAX_V,          0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, MIN_V,          0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, 32'sd0,         0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, 32'sd100,       0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, -32'sd100,      0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, 32'sh7fff_fffe, 0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, 32'sh8000_0001, 0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, 32'sd42,        0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, -32'sd42,       0, ST_INSERTED,  '0,    0);
    plan_row(CMD_INSERT, 32'sd9,         1, ST_FULL,      32'sd9, 0);
    plan_row(CMD_LIST,   32'shffff_ffff, 0, ST_INSERTED,  '0,    0);
    plan_row(CMD_DELETE, MIN_V,          0, ST_INSERTED,  '0,    0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (plan[k]) send(plan[k].cmd, plan[k].val, $urandom_range(0, 4), plan[k].typed,
                           plan[k].res);

    pool[0] = MIN_V;
    pool[1] = MAX_V;
    pool[2] = '0;
    pool[3] = -32'sd1;
    pool[4] = 32'sd1;
    for (int k = 5; k < 8; k++) pool[k] = $urandom;
    filling = 1'b1;
    no_idle = 1'b0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // sweep between full and empty so both ends get exercised
      if (stored_count == CAP && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (stored_count == 0 && $urandom_range(0, 2) == 0) filling = 1'b1;
      if ($urandom_range(0, 39) == 0) no_idle = !no_idle;

      r = $urandom_range(0, 99);
      ins_pct = filling ? 55 : 20;
      if (r < 8) c = CMD_LIST;
      else if (r < 8 + ins_pct) c = CMD_INSERT;
      else if (r < 8 + ins_pct + (100 - 8 - ins_pct) * 2 / 3) c = CMD_DELETE;
      else c = CMD_SEARCH;

      r = $urandom_range(0, 99);
      if (c != CMD_INSERT && c != CMD_LIST && stored_count > 0 && r < 60)
        v = stored_vals[$urandom_range(0, stored_count - 1)];
      else if (r < 75) v = pool[$urandom_range(0, 7)];
      else v = $urandom;

      gap = no_idle ? 0 : $urandom_range(0, 4);
      send(c, v, gap, 1'b0, none);
    end
    start = 1'b0;

    while (expected_results.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d commands, %0d results checked, %0d full inserts, %0d misses",
             n_commands, n_checked, n_full, n_miss);
    $display("empty lists %0d, longest list %0d of %0d", n_empty_list, n_longest_list, CAP);
    if (n_errors == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
